/* hw/rtl/binary_heap_priority_queue_macros.svh */
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_macros
// Assertion macros used by the heap queue controller.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define BHPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define BHPQ_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* hw/rtl/bhpq_pkg.sv */
// ----------------------------------------------------------------------------
// bhpq_pkg
// Types, codes and command structs shared by the heap queue modules.
// ----------------------------------------------------------------------------
package bhpq_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned CountW = 11;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_PEEK   = 2'd2,
    FUNC_POP    = 2'd3
  } func_e;

  typedef struct packed {
    func_e             func;
    logic [KeyW-1:0]   operand_value;
  } req_t;

  typedef struct packed {
    logic [KeyW-1:0]   top_value;
    logic              heap_empty;
    logic [CountW-1:0] entry_count;
    logic              op_ok;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_WR,
    ST_UP_RD,
    ST_UP_WAIT,
    ST_UP_CMP,
    ST_SCAN_RD,
    ST_SCAN_WAIT,
    ST_SCAN_CMP,
    ST_LAST_RD,
    ST_LAST_WAIT,
    ST_MOVE_WR,
    ST_CUR_RD,
    ST_CUR_WAIT,
    ST_HOME_RD,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_WAITL,
    ST_DN_WAITR,
    ST_DN_CMP,
    ST_TOP_RD,
    ST_TOP_WAIT,
    ST_RESP
  } state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic load_req;     // capture request
    logic rd_en;        // read memory
    logic [2:0] rd_sel; // address source
    logic cap_cur;      // read data -> cur key
    logic cap_oth;      // read data -> other key (parent/left)
    logic cap_rgt;      // read data -> right key
    logic cap_top;      // read data -> top
    logic wr_new;       // write operand at count, count++
    logic wr_move;      // write cur key (last) at pos
    logic swap_up;      // swap pos with parent
    logic swap_dn;      // swap pos with picked child
    logic pos_zero;     // pos := 0
    logic pos_last;     // count--, save pos as the home slot
    logic pos_inc;      // scan pos++
    logic pos_home;     // pos := home slot
    logic set_fail;
    logic clr_top;
  } cmd_t;

  localparam logic [2:0] SEL_POS    = 3'd0;
  localparam logic [2:0] SEL_PARENT = 3'd1;
  localparam logic [2:0] SEL_LEFT   = 3'd2;
  localparam logic [2:0] SEL_RIGHT  = 3'd3;
  localparam logic [2:0] SEL_LAST   = 3'd4;
  localparam logic [2:0] SEL_ZERO   = 3'd5;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic       pos_zero;
    logic       scan_end;   // pos >= count
    logic       match;      // cur key equals operand
    logic       up_swap;    // cur ranks before parent
    logic       has_left;
    logic       has_right;
    logic       dn_swap;    // picked child ranks before cur
    logic       moved_last; // deleted slot was the last
    func_e      func;
  } sts_t;

endpackage

/* hw/rtl/binary_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// Binary heap of signed 64-bit keys, min or max order, one memory port.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                    Payload
// request   in         start, busy                  req_i (func, operand_value)
// result    out        done_o strobe                rsp_o (top, empty, count, ok)
// config    in         cfg_valid_i, cfg_ready_o     cfg_data_i (min_order)
//
// A request runs through dispatch, its operation, the top read and the
// result strobe; busy drops the cycle after the strobe. Insert climbs one
// level per parent read, compare and swap; pop descends one level per
// child reads, compare and swap. Delete scans entry by entry up to the
// count, then sifts up, rereads its slot and sifts down; one access a cycle.
// Reset empties the heap and selects min order; memory needs no clearing.
// The result strobe lasts one cycle; the receiver cannot stall it.
module binary_heap_priority_queue
  import bhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic cfg_data_i
);

  cmd_t cmd;
  sts_t sts;
  logic min_order_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                          min_order_q <= 1'b1;
    else if (cfg_valid_i && cfg_ready_o) min_order_q <= cfg_data_i;
  end

  bhpq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  bhpq_datapath #(.Capacity(CAPACITY)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .min_order_i (min_order_q),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_o       (rsp_o)
  );

endmodule

/* hw/rtl/bhpq_datapath.sv */
// ----------------------------------------------------------------------------
// bhpq_datapath
// Heap memory, count, position and key registers of the heap queue.
// ----------------------------------------------------------------------------
module bhpq_datapath
  import bhpq_pkg::*;
#(
  parameter int unsigned Capacity = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        min_order_i,
  input  req_t        req_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output rsp_t        rsp_o
);

  localparam int unsigned AddrW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned PosW  = CntW + 1;

  logic [KeyW-1:0] mem [Capacity];

  req_t            req_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] home_q;
  logic [KeyW-1:0] cur_q, oth_q, rgt_q, top_q, rdata_q;
  logic            fail_q;
  logic [PosW-1:0] rd_addr, wr_addr, parent, left, right;
  logic [KeyW-1:0] wr_data;
  logic            wr_en;
  logic            pick_right;
  logic [KeyW-1:0] pick_key;

  function automatic logic ranks_before(input logic mo, input logic [KeyW-1:0] a,
                                        input logic [KeyW-1:0] b);
    logic sa_lt;
    sa_lt = $signed(a) < $signed(b);
    return mo ? sa_lt : ($signed(a) > $signed(b));
  endfunction

  assign parent = (pos_q - PosW'(1)) >> 1;
  assign left   = {pos_q[PosW-2:0], 1'b1};
  assign right  = left + PosW'(1);

  assign pick_right = sts_o.has_right && !ranks_before(min_order_i, oth_q, rgt_q);
  assign pick_key   = pick_right ? rgt_q : oth_q;

  always_comb begin
    unique case (cmd_i.rd_sel)
      SEL_POS:    rd_addr = pos_q;
      SEL_PARENT: rd_addr = parent;
      SEL_LEFT:   rd_addr = left;
      SEL_RIGHT:  rd_addr = right;
      SEL_LAST:   rd_addr = PosW'(cnt_q) - PosW'(1);
      default:    rd_addr = '0;
    endcase
  end

  // Writes: one per cycle; a swap writes the displaced key at the old slot,
  // and the following wr_move writes the traveling key at the new slot.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos_q;
    wr_data = cur_q;
    if (cmd_i.wr_new) begin
      wr_en   = 1'b1;
      wr_addr = PosW'(cnt_q);
      wr_data = req_q.operand_value;
    end else if (cmd_i.wr_move) begin
      wr_en   = 1'b1;
      wr_addr = pos_q;
      wr_data = cur_q;
    end else if (cmd_i.swap_up) begin
      wr_en   = 1'b1;
      wr_addr = pos_q;
      wr_data = oth_q;
    end else if (cmd_i.swap_dn) begin
      wr_en   = 1'b1;
      wr_addr = pos_q;
      wr_data = pick_key;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr[AddrW-1:0]] <= wr_data;
    if (cmd_i.rd_en) rdata_q <= mem[rd_addr[AddrW-1:0]];
  end

  always_comb begin
    cnt_d = cnt_q;
    pos_d = pos_q;
    if (cmd_i.wr_new) begin
      cnt_d = cnt_q + CntW'(1);
      pos_d = PosW'(cnt_q);
    end
    if (cmd_i.pos_last) cnt_d = cnt_q - CntW'(1);
    if (cmd_i.pos_zero) pos_d = '0;
    if (cmd_i.pos_inc)  pos_d = pos_q + PosW'(1);
    if (cmd_i.pos_home) pos_d = home_q;
    if (cmd_i.swap_up)  pos_d = parent;
    if (cmd_i.swap_dn)  pos_d = pick_right ? right : left;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pos_q  <= '0;
      fail_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      pos_q <= pos_d;
      if (cmd_i.load_req)     fail_q <= 1'b0;
      else if (cmd_i.set_fail) fail_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.cap_cur)  cur_q <= rdata_q;
    if (cmd_i.cap_oth)  oth_q <= rdata_q;
    if (cmd_i.cap_rgt)  rgt_q <= rdata_q;
    if (cmd_i.cap_top)  top_q <= rdata_q;
    else if (cmd_i.clr_top) top_q <= '0;
    if (cmd_i.wr_new)   cur_q <= req_q.operand_value;
    // hold the deleted slot for the sift down after the sift up
    if (cmd_i.pos_last) home_q <= pos_q;
  end

  always_comb begin
    sts_o.full       = PosW'(cnt_q) >= PosW'(Capacity);
    sts_o.empty      = cnt_q == '0;
    sts_o.pos_zero   = pos_q == '0;
    sts_o.scan_end   = pos_q >= PosW'(cnt_q);
    sts_o.match      = cur_q == req_q.operand_value;
    sts_o.up_swap    = ranks_before(min_order_i, cur_q, oth_q);
    sts_o.has_left   = left < PosW'(cnt_q);
    sts_o.has_right  = right < PosW'(cnt_q);
    sts_o.dn_swap    = ranks_before(min_order_i, pick_key, cur_q);
    sts_o.moved_last = pos_q >= PosW'(cnt_q);
    sts_o.func       = req_q.func;
  end

  assign rsp_o.top_value   = top_q;
  assign rsp_o.heap_empty  = cnt_q == '0;
  assign rsp_o.entry_count = CountW'(cnt_q);
  assign rsp_o.op_ok       = !fail_q;

endmodule

/* hw/rtl/bhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// bhpq_ctrl
// Sequencer for insert, delete, peek and pop over the heap datapath.
// ----------------------------------------------------------------------------
`include "binary_heap_priority_queue_macros.svh"

module bhpq_ctrl
  import bhpq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output logic busy_o,
  output logic done_o,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = SEL_POS;
    busy_o  = state_q != ST_IDLE;
    done_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load_req = 1'b1;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.func)
          FUNC_INSERT: begin
            if (sts_i.full) begin
              cmd_o.set_fail = 1'b1;
              state_d = ST_TOP_RD;
            end else begin
              state_d = ST_INS_WR;
            end
          end
          FUNC_DELETE: begin
            cmd_o.pos_zero = 1'b1;
            state_d = ST_SCAN_RD;
          end
          FUNC_POP: begin
            if (sts_i.empty) begin
              cmd_o.set_fail = 1'b1;
              state_d = ST_TOP_RD;
            end else begin
              cmd_o.pos_zero = 1'b1;
              state_d = ST_LAST_RD;
            end
          end
          default: state_d = ST_TOP_RD;
        endcase
      end
      ST_INS_WR: begin
        cmd_o.wr_new = 1'b1;
        state_d = ST_UP_RD;
      end
      // Sift up: cur key travels in cur_q, memory holds it at pos
      ST_UP_RD: begin
        if (sts_i.pos_zero) begin
          if (sts_i.func == FUNC_DELETE) begin
            cmd_o.pos_home = 1'b1;
            state_d = ST_HOME_RD;
          end else begin
            state_d = ST_TOP_RD;
          end
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = SEL_PARENT;
          state_d = ST_UP_WAIT;
        end
      end
      ST_UP_WAIT: begin
        cmd_o.cap_oth = 1'b1;
        state_d = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if (sts_i.up_swap) begin
          cmd_o.swap_up = 1'b1;
          state_d = ST_MOVE_WR;
        end else if (sts_i.func == FUNC_DELETE) begin
          // sift down restarts at the deleted slot, whatever sits there now
          cmd_o.pos_home = 1'b1;
          state_d = ST_HOME_RD;
        end else begin
          state_d = ST_TOP_RD;
        end
      end
      ST_SCAN_RD: begin
        if (sts_i.scan_end) begin
          cmd_o.set_fail = 1'b1;
          state_d = ST_TOP_RD;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d = ST_SCAN_WAIT;
        end
      end
      ST_SCAN_WAIT: begin
        cmd_o.cap_cur = 1'b1;
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts_i.match) begin
          state_d = ST_LAST_RD;
        end else begin
          cmd_o.pos_inc = 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_LAST_RD: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_sel   = SEL_LAST;
        cmd_o.pos_last = 1'b1;
        state_d = ST_LAST_WAIT;
      end
      ST_LAST_WAIT: begin
        cmd_o.cap_cur = 1'b1;
        state_d = ST_CUR_RD;
      end
      ST_CUR_RD: begin
        // moved slot past the end: entry simply dropped
        if (sts_i.moved_last) begin
          state_d = ST_TOP_RD;
        end else begin
          cmd_o.wr_move = 1'b1;
          state_d = (sts_i.func == FUNC_POP) ? ST_DN_RDL : ST_UP_RD;
        end
      end
      // After a swap, write the traveling key at its new position
      ST_MOVE_WR: begin
        cmd_o.wr_move = 1'b1;
        state_d = ST_UP_RD;
      end
      ST_HOME_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d = ST_CUR_WAIT;
      end
      ST_CUR_WAIT: begin
        cmd_o.cap_cur = 1'b1;
        state_d = ST_DN_RDL;
      end
      ST_DN_RDL: begin
        if (!sts_i.has_left) begin
          state_d = ST_TOP_RD;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = SEL_LEFT;
          state_d = ST_DN_WAITL;
        end
      end
      ST_DN_WAITL: begin
        cmd_o.cap_oth = 1'b1;
        if (sts_i.has_right) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = SEL_RIGHT;
          state_d = ST_DN_WAITR;
        end else begin
          state_d = ST_DN_CMP;
        end
      end
      ST_DN_WAITR: begin
        cmd_o.cap_rgt = 1'b1;
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        if (sts_i.dn_swap) begin
          cmd_o.swap_dn = 1'b1;
          state_d = ST_DN_RDR;
        end else begin
          state_d = ST_TOP_RD;
        end
      end
      ST_DN_RDR: begin
        cmd_o.wr_move = 1'b1;
        state_d = ST_DN_RDL;
      end
      ST_TOP_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = SEL_ZERO;
        state_d = ST_TOP_WAIT;
      end
      ST_TOP_WAIT: begin
        if (sts_i.empty) cmd_o.clr_top = 1'b1;
        else             cmd_o.cap_top = 1'b1;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        done_o  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `BHPQ_ASSERT(a_done_once, done_o |=> !done_o, "result strobe held two cycles")
  `BHPQ_ASSERT(a_accept_idle, (start_i && !busy_o) |=> busy_o, "request not taken")
  `BHPQ_NEVER(a_one_write, cmd_o.wr_new && cmd_o.swap_dn, "two writes in a cycle")
  `BHPQ_NEVER(a_done_busy, done_o && !busy_o, "result strobe while idle")

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heap priority queue testbench
// Drives insert, delete, peek and pop requests in min and max order, keeps a
// heap model of its own and checks every result strobe field by field.
// ----------------------------------------------------------------------------
module testbench;
  import bhpq_pkg::*;

  localparam int unsigned HEAP_CAP  = 1024;
  localparam int unsigned CYC_LIMIT = 4000000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic done_o;
  rsp_t rsp_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  binary_heap_priority_queue #(.CAPACITY(HEAP_CAP)) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // heap model
  logic [63:0] keys [HEAP_CAP];
  int unsigned key_cnt;
  bit          min_top;

  rsp_t   rsp_queue[$];
  int     err_cnt;
  longint cycle_cnt;
  logic [63:0] pool [8];

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYC_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  function automatic bit ranks_ahead(input logic [63:0] a, input logic [63:0] b);
    if (min_top) return $signed(a) < $signed(b);
    return $signed(a) > $signed(b);
  endfunction

  function automatic void swap_keys(input int unsigned i, input int unsigned j);
    logic [63:0] t;
    t = keys[i];
    keys[i] = keys[j];
    keys[j] = t;
  endfunction

  function automatic void bubble_up(input int unsigned pos);
    int unsigned par;
    while (pos > 0) begin
      par = (pos - 1) / 2;
      if (!ranks_ahead(keys[pos], keys[par])) return;
      swap_keys(pos, par);
      pos = par;
    end
  endfunction

  function automatic void bubble_down(input int unsigned pos);
    int unsigned lc, pick;
    forever begin
      lc = 2 * pos + 1;
      if (lc >= key_cnt) return;
      pick = lc;
      if (lc + 1 < key_cnt && !ranks_ahead(keys[lc], keys[lc + 1])) pick = lc + 1;
      if (!ranks_ahead(keys[pick], keys[pos])) return;
      swap_keys(pick, pos);
      pos = pick;
    end
  endfunction

  function automatic rsp_t heap_apply(input req_t rq);
    rsp_t r;
    bit   ok;
    ok = 1'b1;
    case (rq.func)
      FUNC_INSERT: begin
        if (key_cnt >= HEAP_CAP) ok = 1'b0;
        else begin
          keys[key_cnt] = rq.operand_value;
          key_cnt++;
          bubble_up(key_cnt - 1);
        end
      end
      FUNC_DELETE: begin
        ok = 1'b0;
        for (int unsigned i = 0; i < key_cnt; i++) begin
          if (keys[i] == rq.operand_value) begin
            key_cnt--;
            keys[i] = keys[key_cnt];
            if (i < key_cnt) begin
              bubble_up(i);
              bubble_down(i);
            end
            ok = 1'b1;
            break;
          end
        end
      end
      FUNC_POP: begin
        if (key_cnt == 0) ok = 1'b0;
        else begin
          key_cnt--;
          keys[0] = keys[key_cnt];
          bubble_down(0);
        end
      end
      default: ;
    endcase
    r.top_value   = key_cnt ? keys[0] : '0;
    r.heap_empty  = (key_cnt == 0);
    r.entry_count = key_cnt[CountW-1:0];
    r.op_ok       = ok;
    return r;
  endfunction

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && done_o) begin
      if (rsp_queue.size() == 0) report("result with no request outstanding");
      else begin
        want = rsp_queue.pop_front();
        if (rsp_o.top_value !== want.top_value)
          report($sformatf("top_value %h, want %h", rsp_o.top_value, want.top_value));
        if (rsp_o.heap_empty !== want.heap_empty)
          report($sformatf("heap_empty %b, want %b", rsp_o.heap_empty, want.heap_empty));
        if (rsp_o.entry_count !== want.entry_count)
          report($sformatf("entry_count %0d, want %0d", rsp_o.entry_count,
                           want.entry_count));
        if (rsp_o.op_ok !== want.op_ok)
          report($sformatf("op_ok %b, want %b", rsp_o.op_ok, want.op_ok));
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // caller sits at a falling edge
  task automatic send_request(input func_e f, input logic [63:0] v);
    req_t rq;
    rsp_t exp_rsp;
    rq.func          = f;
    rq.operand_value = v;
    repeat (pick_gap()) @(negedge clk_i);
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy);
    exp_rsp   = heap_apply(rq);
    rsp_queue = {rsp_queue, exp_rsp};
    @(negedge clk_i);
    start <= 1'b0;
    req_i <= '{func: func_e'($urandom_range(0, 3)), operand_value: {$urandom, $urandom}};
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (rsp_queue.size() != 0) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_order(input bit v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    min_top = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_request(FUNC_PEEK, '0);
    send_request(FUNC_POP, '1);
    send_request(FUNC_DELETE, 64'd5);
    send_request(FUNC_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(FUNC_INSERT, 64'h8000_0000_0000_0000);
    send_request(FUNC_INSERT, '0);
    send_request(FUNC_INSERT, '1);
    send_request(FUNC_INSERT, 64'd1);
    send_request(FUNC_INSERT, 64'd1);
    send_request(FUNC_DELETE, 64'd42);
    send_request(FUNC_DELETE, 64'd1);
    // flip order with entries held: store stays as is
    write_order(1'b0);
    send_request(FUNC_PEEK, 64'd9);
    send_request(FUNC_INSERT, 64'd100);
    send_request(FUNC_DELETE, 64'h8000_0000_0000_0000);
    send_request(FUNC_POP, '0);
    send_request(FUNC_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(FUNC_DELETE, '0);
    repeat (6) send_request(FUNC_POP, '0);
    write_order(1'b1);
  endtask

  task automatic test_random(input bit order, input int n);
    logic [63:0] v;
    int unsigned r;
    func_e f;
    write_order(order);
    for (int k = 0; k < 8; k++) pool[k] = {$urandom, $urandom};
    pool[0] = 64'h8000_0000_0000_0000;
    pool[1] = 64'h7FFF_FFFF_FFFF_FFFF;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      // hold the heap small so delete scans stay short
      if (key_cnt > 48) r = (r < 50) ? 95 : 50;
      if (r < 45) f = FUNC_INSERT;
      else if (r < 70) f = FUNC_DELETE;
      else if (r < 80) f = FUNC_PEEK;
      else f = FUNC_POP;
      if (f == FUNC_DELETE && key_cnt != 0 && $urandom_range(0, 3) != 0)
        v = keys[$urandom_range(0, key_cnt - 1)];
      else if ($urandom_range(0, 2) == 0) v = {$urandom, $urandom};
      else v = pool[$urandom_range(0, 7)];
      send_request(f, v);
    end
    while (key_cnt != 0) send_request(FUNC_POP, '0);
  endtask

  initial begin
    err_cnt     = 0;
    cycle_cnt   = 0;
    key_cnt     = 0;
    min_top     = 1'b1;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1'b1, 170);
    test_random(1'b0, 170);
    test_random(1'b1, 170);
    drain();
    if (err_cnt == 0 && rsp_queue.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
